// ===== rtl/erg_pkg.sv =====
// Shared types, constants and the smooth-curve table builder for the easing ramp generator.
`default_nettype none

package erg_pkg;

    // Sizing
    localparam int MAX_LENGTH  = 64;
    localparam int PHASE_STEPS = 1024;

    localparam int LEN_W    = 7;
    localparam int WEIGHT_W = 16;
    localparam int POS_W    = 6;
    localparam int ONE_Q15  = 32768;

    localparam int SPAN_W = $clog2(MAX_LENGTH);
    localparam int DSR_W  = SPAN_W + 1;

    localparam int LIN_DIVIDEND = 2 * ONE_Q15;
    localparam int SMO_DIVIDEND = 2 * PHASE_STEPS;
    localparam int DIVD_MAX     = (LIN_DIVIDEND > SMO_DIVIDEND) ? LIN_DIVIDEND : SMO_DIVIDEND;
    localparam int DIVD_W       = $clog2(DIVD_MAX + 1);
    localparam int DIV_CNT_W    = $clog2(DIVD_W);

    localparam int PHASE_W = $clog2(PHASE_STEPS + 1);
    localparam int NSAT_W  = (SPAN_W + 1 > LEN_W) ? SPAN_W + 1 : LEN_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
    localparam logic [63:0] HALF_Q46 = 64'h0000_2000_0000_0000;

    // Channel payloads
    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             mode;
    } req_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [POS_W-1:0]    position;
        logic                last;
    } wgt_t;

    // One classified request; span of zero means a single full-scale weight
    typedef struct packed {
        logic [SPAN_W-1:0] span;
        logic              smooth;
    } job_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DSR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [DSR_W-1:0]  remainder;
    } div_rsp_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_RUN
    } back_state_t;

    typedef logic [WEIGHT_W-1:0] smooth_rom_t [0:PHASE_STEPS];

    // (a * b) >> 60, truncated to 64 bits
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    // Unsigned shift-and-subtract long division; runs only while the curve table is built
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // cos(pi * k / PHASE_STEPS) in Q60 for k up to half the phase range
    function automatic logic signed [63:0] cos_q60(input logic [63:0] k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        dvs;
        logic signed [63:0] sum;
        x    = (PI_Q60 / PHASE_STEPS) * k + ((PI_Q60 % PHASE_STEPS) * k) / PHASE_STEPS;
        x2   = mul_q60(x, x);
        term = ONE_Q60;
        sum  = signed'(ONE_Q60);
        for (int n = 1; n <= 16; n++)
        begin
            dvs  = 64'((2 * n - 1) * (2 * n));
            term = udiv64(mul_q60(term, x2), dvs);
            if ((n % 2) == 1)
            begin
                sum = sum - signed'(term);
            end
            else
            begin
                sum = sum + signed'(term);
            end
        end
        return sum;
    endfunction

    // round(32768 * (1 - cos(pi * k / PHASE_STEPS)) / 2)
    function automatic logic [WEIGHT_W-1:0] smooth_entry(input int k);
        logic signed [63:0] v;
        logic [63:0]        r;
        if (2 * k <= PHASE_STEPS)
        begin
            v = signed'(ONE_Q60) - cos_q60(64'(k));
        end
        else
        begin
            v = signed'(ONE_Q60) + cos_q60(64'(PHASE_STEPS - k));
        end
        if (v < 0)
        begin
            v = '0;
        end
        r = (unsigned'(v) + HALF_Q46) >> 46;
        return r[WEIGHT_W-1:0];
    endfunction

    function automatic smooth_rom_t smooth_table();
        smooth_rom_t t;
        for (int k = 0; k <= PHASE_STEPS; k++)
        begin
            t[k] = smooth_entry(k);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/erg_front.sv =====
// Request intake: length clamp, short-run detection and a small job queue.
`default_nettype none

module erg_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire erg_pkg::req_t  req,
    output logic                job_valid,
    output erg_pkg::job_t       job,
    input  wire logic           job_pop
);

    erg_pkg::job_t                     mem_reg [erg_pkg::QUEUE_DEPTH];
    logic [erg_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [erg_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [erg_pkg::QCNT_W-1:0]        count_reg, count_next;

    logic [erg_pkg::NSAT_W-1:0]        n_ext;
    logic [erg_pkg::NSAT_W-1:0]        n_sat;
    logic                              short_run;
    erg_pkg::job_t                     new_job;
    logic                              push;
    logic                              pop;

    // Classify the incoming request
    always_comb
    begin
        n_ext     = erg_pkg::NSAT_W'(req.length);
        n_sat     = (n_ext > erg_pkg::NSAT_W'(erg_pkg::MAX_LENGTH))
                    ? erg_pkg::NSAT_W'(erg_pkg::MAX_LENGTH) : n_ext;
        short_run = (req.length <= erg_pkg::LEN_W'(1));
        new_job.span   = short_run ? '0 : erg_pkg::SPAN_W'(n_sat - erg_pkg::NSAT_W'(1));
        new_job.smooth = req.mode & ~short_run;
    end

    assign req_stall = (count_reg == erg_pkg::QCNT_W'(erg_pkg::QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = mem_reg[rd_ptr_reg];

    assign push = req_valid & ~req_stall;
    assign pop  = job_pop & job_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == erg_pkg::QPTR_W'(erg_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + erg_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == erg_pkg::QPTR_W'(erg_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + erg_pkg::QPTR_W'(1);
        end
        count_next = count_reg + erg_pkg::QCNT_W'(push) - erg_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= new_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/erg_div.sv =====
// Restoring divider, one quotient bit per cycle, for the per-run step setup.
`default_nettype none

module erg_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire erg_pkg::div_req_t  div_req,
    output erg_pkg::div_rsp_t       div_rsp
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [erg_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [erg_pkg::DIVD_W-1:0]      quo_reg, quo_next;
    logic [erg_pkg::DSR_W-1:0]       rem_reg, rem_next;
    logic [erg_pkg::DSR_W-1:0]       dsr_reg, dsr_next;

    logic [erg_pkg::DSR_W:0]         shifted;
    logic [erg_pkg::DSR_W:0]         diff;
    logic                            fits;
    logic                            last_step;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[erg_pkg::DIVD_W-1]};
        fits      = (shifted >= {1'b0, dsr_reg});
        diff      = shifted - {1'b0, dsr_reg};
        last_step = (cnt_reg == erg_pkg::DIV_CNT_W'(erg_pkg::DIVD_W - 1));

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;

        if (div_req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = div_req.dividend;
            rem_next  = '0;
            dsr_next  = div_req.divisor;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[erg_pkg::DIVD_W-2:0], fits};
            rem_next  = fits ? diff[erg_pkg::DSR_W-1:0] : shifted[erg_pkg::DSR_W-1:0];
            cnt_next  = cnt_reg + erg_pkg::DIV_CNT_W'(1);
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign div_rsp.done      = done_reg;
    assign div_rsp.quotient  = quo_reg;
    assign div_rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/erg_back.sv =====
// Run sequencer: step setup, quotient/remainder stepping, curve lookup and output register.
`default_nettype none

module erg_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               job_valid,
    input  wire erg_pkg::job_t      job,
    output logic                    job_pop,
    output erg_pkg::div_req_t       div_req,
    input  wire erg_pkg::div_rsp_t  div_rsp,
    output logic                    wgt_valid,
    input  wire logic               wgt_stall,
    output erg_pkg::wgt_t           wgt
);

    localparam erg_pkg::smooth_rom_t SMOOTH_ROM = erg_pkg::smooth_table();

    erg_pkg::back_state_t            state_reg, state_next;
    logic [erg_pkg::SPAN_W-1:0]      span_reg, span_next;
    logic                            smooth_reg, smooth_next;
    logic [erg_pkg::SPAN_W-1:0]      pos_reg, pos_next;
    logic [erg_pkg::DIVD_W-1:0]      q_reg, q_next;
    logic [erg_pkg::DSR_W-1:0]       r_reg, r_next;
    logic [erg_pkg::DIVD_W-1:0]      dq_reg, dq_next;
    logic [erg_pkg::DSR_W-1:0]       dr_reg, dr_next;
    logic                            wgt_valid_reg, wgt_valid_next;
    erg_pkg::wgt_t                   wgt_reg;

    logic                            last_now;
    logic                            load;
    logic [erg_pkg::DSR_W:0]         r_sum;
    logic [erg_pkg::DSR_W:0]         span_x2;
    logic                            wrap;
    logic [erg_pkg::DSR_W:0]         r_wrapped;
    logic [erg_pkg::DSR_W-1:0]       r_step;
    logic [erg_pkg::DIVD_W-1:0]      q_step;

    // Advance the running quotient by dq, the remainder by dr, carry once on wrap
    always_comb
    begin
        last_now  = (pos_reg == span_reg);
        load      = (state_reg == erg_pkg::BK_RUN) && (!wgt_valid_reg || !wgt_stall);
        r_sum     = {1'b0, r_reg} + {1'b0, dr_reg};
        span_x2   = {1'b0, span_reg, 1'b0};
        wrap      = (r_sum >= span_x2);
        r_wrapped = wrap ? (r_sum - span_x2) : r_sum;
        r_step    = r_wrapped[erg_pkg::DSR_W-1:0];
        q_step    = q_reg + dq_reg + erg_pkg::DIVD_W'(wrap);
    end

    always_comb
    begin
        state_next     = state_reg;
        span_next      = span_reg;
        smooth_next    = smooth_reg;
        pos_next       = pos_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        dq_next        = dq_reg;
        dr_next        = dr_reg;
        job_pop        = 1'b0;
        div_req        = '0;
        wgt_valid_next = load ? 1'b1 : (wgt_valid_reg && wgt_stall);

        case (state_reg)
            erg_pkg::BK_IDLE:
            begin
                if (job_valid) begin
                    job_pop     = 1'b1;
                    span_next   = job.span;
                    smooth_next = job.smooth;
                    pos_next    = '0;
                    q_next      = '0;
                    r_next      = erg_pkg::DSR_W'(job.span);
                    if (job.span == '0) begin
                        state_next = erg_pkg::BK_RUN;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = job.smooth
                                           ? erg_pkg::DIVD_W'(erg_pkg::SMO_DIVIDEND)
                                           : erg_pkg::DIVD_W'(erg_pkg::LIN_DIVIDEND);
                        div_req.divisor  = {job.span, 1'b0};
                        state_next       = erg_pkg::BK_DIV;
                    end
                end
            end
            erg_pkg::BK_DIV:
            begin
                if (div_rsp.done) begin
                    dq_next    = div_rsp.quotient;
                    dr_next    = div_rsp.remainder;
                    state_next = erg_pkg::BK_RUN;
                end
            end
            erg_pkg::BK_RUN:
            begin
                if (load) begin
                    if (last_now) begin
                        state_next = erg_pkg::BK_IDLE;
                    end else begin
                        pos_next = pos_reg + erg_pkg::SPAN_W'(1);
                        q_next   = q_step;
                        r_next   = r_step;
                    end
                end
            end
            default:
            begin
                state_next = erg_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= erg_pkg::BK_IDLE;
            wgt_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wgt_valid_reg <= wgt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg   <= span_next;
        smooth_reg <= smooth_next;
        pos_reg    <= pos_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        dq_reg     <= dq_next;
        dr_reg     <= dr_next;
    end

    // Output register doubles as the curve table's read register
    always_ff @(posedge clk)
    begin
        if (load) begin
            if (smooth_reg) begin
                wgt_reg.weight <= SMOOTH_ROM[q_reg[erg_pkg::PHASE_W-1:0]];
            end else if (last_now) begin
                wgt_reg.weight <= erg_pkg::WEIGHT_W'(erg_pkg::ONE_Q15);
            end else begin
                wgt_reg.weight <= q_reg[erg_pkg::WEIGHT_W-1:0];
            end
            wgt_reg.position <= erg_pkg::POS_W'(pos_reg);
            wgt_reg.last     <= last_now;
        end
    end

    assign wgt_valid = wgt_valid_reg;
    assign wgt       = wgt_reg;

endmodule

`default_nettype wire

// ===== rtl/easing_ramp_generator_core.sv =====
// Top level of the easing ramp generator: request queue, step divider and run sequencer.
`default_nettype none

// Channel   Handshake                   Payload    Carries
// --------  --------------------------  ---------  ----------------------------------
// request   req_valid in, req_stall out   req        length, mode
// weight    wgt_valid out, wgt_stall in   wgt        weight, position, last
//
// A request of N weights (N clamped to the maximum length) runs through the run
// sequencer in order: it picks up the job, the bit-serial divider forms the
// per-weight step, the step is loaded, then one weight per cycle while the output
// is not stalled. A length of 0 or 1 skips the divider.
// The two-entry job queue keeps taking requests while a run is in progress, until it is full.
// rst_n clears the queue, the divider and sequencer control, and the output valid.
// A stalled weight holds in the output register; the sequencer waits with it.

module easing_ramp_generator_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire erg_pkg::req_t  req,
    output logic                wgt_valid,
    input  wire logic           wgt_stall,
    output erg_pkg::wgt_t       wgt
);

    logic                job_valid;
    erg_pkg::job_t       job;
    logic                job_pop;
    erg_pkg::div_req_t   div_req;
    erg_pkg::div_rsp_t   div_rsp;

    // Accept and classify requests, hold them in a short queue
    erg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    // Step quotient and remainder: 2x full scale (2x phase range if smooth) over 2x the span
    erg_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // Step through the run and transfer one weight per cycle while the output is not stalled
    erg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .wgt_valid (wgt_valid),
        .wgt_stall (wgt_stall),
        .wgt       (wgt)
    );

    // Within a run, the next weight follows at once with the next position
    assert property (@(posedge clk) disable iff (!rst_n)
        (wgt_valid && !wgt_stall && !wgt.last) |=>
            (wgt_valid && (wgt.position == erg_pkg::POS_W'($past(wgt.position) + 1'b1))))
    else $error("run broken or position skipped after a non-final transfer");

    // A run ends on full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        (wgt_valid && wgt.last) |-> (wgt.weight == erg_pkg::WEIGHT_W'(erg_pkg::ONE_Q15)))
    else $error("final weight of a run is not full scale");

    // No weight exceeds full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        wgt_valid |-> (wgt.weight <= erg_pkg::WEIGHT_W'(erg_pkg::ONE_Q15)))
    else $error("weight above full scale");

    // After the final transfer of a run, the next weight shown starts a fresh run
    assert property (@(posedge clk) disable iff (!rst_n)
        (wgt_valid && !wgt_stall && wgt.last) |=> (!wgt_valid || (wgt.position == '0)))
    else $error("new run does not start at position zero");

endmodule

`default_nettype wire
